/* design/gtlca_pkg.sv */
// gtlca_pkg: shared types and constants for the growing tree lca core
// no dependencies
`timescale 1ns / 1ps

package gtlca_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 10;
    localparam int NODE_W     = 10;
    localparam int CNT_W      = NODE_W + 1;
    localparam int LVL_W      = $clog2(LOG_LEVELS);
    localparam int ANC_DEPTH  = MAX_NODES * LOG_LEVELS;
    localparam int ANC_AW     = $clog2(ANC_DEPTH);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_NODE  = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0] answer;
        logic [1:0]        status;
    } result_t;

endpackage

/* design/gtlca_ram.sv */
// gtlca_ram: single write port, single read port memory, registered read data
// no dependencies
`timescale 1ns / 1ps

module gtlca_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/growing_tree_lca_with_deletions_core.sv */
// growing_tree_lca_with_deletions_core: top level, command sequencer over three memories
// depends on gtlca_pkg and gtlca_ram
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its single result
// appears on result for one cycle with done high and must be captured then.
// Errors and the unused op answer in the cycle after the command. Insert
// writes the new node's depth, link and level-zero ancestor, then reads the
// ancestor table once per level. Erase reads the node's parent, then follows
// union-find links in two walks, from the node and from its parent. Query
// reads both depths, lifts the deeper node with one ancestor-table read per
// level jump, descends both nodes together level by level (skipped when
// lifting already meets), and ends with one union-find walk. The single
// ancestor-table read port serializes these reads. No clearing pass is needed.
module growing_tree_lca_with_deletions_core
    import gtlca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_I_DEP  = 15'b000000000000010,
        S_I_LVL  = 15'b000000000000100,
        S_E_ANC  = 15'b000000000001000,
        S_FIND   = 15'b000000000010000,
        S_Q_DA   = 15'b000000000100000,
        S_Q_DB   = 15'b000000001000000,
        S_Q_LIFT = 15'b000000010000000,
        S_Q_LFTW = 15'b000000100000000,
        S_Q_CMP  = 15'b000001000000000,
        S_Q_UPA  = 15'b000010000000000,
        S_Q_UPB  = 15'b000100000000000,
        S_Q_UPC  = 15'b001000000000000,
        S_Q_FIN  = 15'b010000000000000,
        S_Q_FINW = 15'b100000000000000
    } state_t;

    typedef enum logic [1:0] {
        RET_X = 2'd0,
        RET_Y = 2'd1,
        RET_Q = 2'd2
    } ret_t;

    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LOG_LEVELS - 1);

    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] row,
                                                   input logic [LVL_W-1:0] lvl);
        return ANC_AW'(row) * ANC_AW'(LOG_LEVELS) + ANC_AW'(lvl);
    endfunction

    state_t            state_reg, state_next;
    ret_t              ret_reg, ret_next;
    logic [NODE_W-1:0] a_reg, a_next, b_reg, b_next, n_reg, n_next;
    logic [NODE_W-1:0] diff_reg, diff_next, da_reg, da_next;
    logic [NODE_W-1:0] pa_reg, pa_next, fv_reg, fv_next, xv_reg, xv_next;
    logic [NODE_W-1:0] yv_reg, yv_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [CNT_W-1:0]  next_node_reg, next_node_next;
    logic              root_erased_reg, root_erased_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;
    logic              anc_zero_reg, dep_zero_reg;

    // memory ports
    logic              anc_we, dep_we, lnk_we;
    logic [ANC_AW-1:0] anc_waddr;
    logic [NODE_W-1:0] anc_wdata, dep_waddr, dep_wdata, lnk_waddr, lnk_wdata;
    logic [NODE_W-1:0] anc_rrow, dep_raddr, lnk_raddr;
    logic [LVL_W-1:0]  anc_rlvl;
    logic [NODE_W-1:0] anc_q, dep_q, lnk_q;
    logic [NODE_W-1:0] anc_val, dep_val, link_val;

    gtlca_ram #(.DEPTH(ANC_DEPTH), .WIDTH(NODE_W)) u_anc (
        .clk   (clk),
        .we    (anc_we),
        .waddr (anc_waddr),
        .wdata (anc_wdata),
        .raddr (anc_addr(anc_rrow, anc_rlvl)),
        .rdata (anc_q)
    );

    gtlca_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_dep (
        .clk   (clk),
        .we    (dep_we),
        .waddr (dep_waddr),
        .wdata (dep_wdata),
        .raddr (dep_raddr),
        .rdata (dep_q)
    );

    gtlca_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_lnk (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (lnk_raddr),
        .rdata (lnk_q)
    );

    // rows of the sentinel and the root are never written and read as zero
    assign anc_val = anc_zero_reg ? '0 : anc_q;
    assign dep_val = dep_zero_reg ? '0 : dep_q;

    always_comb
    begin
        if (fv_reg == NODE_W'(0))
        begin
            link_val = '0;
        end
        else if (fv_reg == NODE_W'(1))
        begin
            link_val = root_erased_reg ? NODE_W'(0) : NODE_W'(1);
        end
        else
        begin
            link_val = lnk_q;
        end
    end

    function automatic logic allocated(input logic [NODE_W-1:0] v,
                                       input logic [CNT_W-1:0] top);
        return (v != NODE_W'(0)) && (CNT_W'(v) <= top);
    endfunction

    always_comb
    begin
        state_next       = state_reg;
        ret_next         = ret_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        n_next           = n_reg;
        diff_next        = diff_reg;
        da_next          = da_reg;
        pa_next          = pa_reg;
        fv_next          = fv_reg;
        xv_next          = xv_reg;
        yv_next          = yv_reg;
        lvl_next         = lvl_reg;
        next_node_next   = next_node_reg;
        root_erased_next = root_erased_reg;
        done_next        = 1'b0;
        res_next         = res_reg;
        anc_we           = 1'b0;
        anc_waddr        = '0;
        anc_wdata        = '0;
        dep_we           = 1'b0;
        dep_waddr        = '0;
        dep_wdata        = '0;
        lnk_we           = 1'b0;
        lnk_waddr        = '0;
        lnk_wdata        = '0;
        anc_rrow         = '0;
        anc_rlvl         = '0;
        dep_raddr        = '0;
        lnk_raddr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next = cmd.node_a;
                    b_next = cmd.node_b;
                    unique case (cmd.op)
                        OP_INSERT:
                        begin
                            if (!allocated(cmd.node_a, next_node_reg))
                            begin
                                done_next = 1'b1;
                                res_next  = '{answer: '0, status: ST_NO_NODE};
                            end
                            else if (next_node_reg + CNT_W'(1) >= CNT_W'(MAX_NODES))
                            begin
                                done_next = 1'b1;
                                res_next  = '{answer: '0, status: ST_FULL};
                            end
                            else
                            begin
                                n_next     = NODE_W'(next_node_reg + CNT_W'(1));
                                dep_raddr  = cmd.node_a;
                                state_next = S_I_DEP;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (!allocated(cmd.node_a, next_node_reg))
                            begin
                                done_next = 1'b1;
                                res_next  = '{answer: '0, status: ST_NO_NODE};
                            end
                            else
                            begin
                                anc_rrow   = cmd.node_a;
                                state_next = S_E_ANC;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (!allocated(cmd.node_a, next_node_reg) ||
                                !allocated(cmd.node_b, next_node_reg))
                            begin
                                done_next = 1'b1;
                                res_next  = '{answer: '0, status: ST_NO_NODE};
                            end
                            else
                            begin
                                dep_raddr  = cmd.node_a;
                                state_next = S_Q_DA;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_next  = '{answer: '0, status: ST_OK};
                        end
                    endcase
                end
            end
            S_I_DEP:
            begin
                dep_we    = 1'b1;
                dep_waddr = n_reg;
                dep_wdata = dep_val + NODE_W'(1);
                lnk_we    = 1'b1;
                lnk_waddr = n_reg;
                lnk_wdata = n_reg;
                anc_we    = 1'b1;
                anc_waddr = anc_addr(n_reg, '0);
                anc_wdata = a_reg;
                anc_rrow  = a_reg;
                anc_rlvl  = '0;
                lvl_next  = LVL_W'(1);
                state_next = S_I_LVL;
            end
            S_I_LVL:
            begin
                anc_we    = 1'b1;
                anc_waddr = anc_addr(n_reg, lvl_reg);
                anc_wdata = anc_val;
                anc_rrow  = anc_val;
                anc_rlvl  = lvl_reg;
                a_next    = anc_val;
                if (lvl_reg == LVL_TOP)
                begin
                    next_node_next = CNT_W'(n_reg);
                    done_next      = 1'b1;
                    res_next       = '{answer: n_reg, status: ST_OK};
                    state_next     = S_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            S_E_ANC:
            begin
                yv_next    = anc_val;
                fv_next    = a_reg;
                lnk_raddr  = a_reg;
                ret_next   = RET_X;
                state_next = S_FIND;
            end
            S_FIND:
            begin
                if (link_val == fv_reg)
                begin
                    case (ret_reg)
                        RET_X:
                        begin
                            xv_next   = fv_reg;
                            fv_next   = yv_reg;
                            lnk_raddr = yv_reg;
                            ret_next  = RET_Y;
                        end
                        RET_Y:
                        begin
                            if (xv_reg != fv_reg)
                            begin
                                if (xv_reg == NODE_W'(1))
                                begin
                                    root_erased_next = 1'b1;
                                end
                                else if (xv_reg != NODE_W'(0))
                                begin
                                    lnk_we    = 1'b1;
                                    lnk_waddr = xv_reg;
                                    lnk_wdata = fv_reg;
                                end
                            end
                            done_next  = 1'b1;
                            res_next   = '{answer: '0, status: ST_OK};
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            res_next   = '{answer: fv_reg, status: ST_OK};
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    fv_next   = link_val;
                    lnk_raddr = link_val;
                end
            end
            S_Q_DA:
            begin
                da_next    = dep_val;
                dep_raddr  = b_reg;
                state_next = S_Q_DB;
            end
            S_Q_DB:
            begin
                if (da_reg < dep_val)
                begin
                    a_next    = b_reg;
                    b_next    = a_reg;
                    diff_next = dep_val - da_reg;
                end
                else
                begin
                    diff_next = da_reg - dep_val;
                end
                lvl_next   = LVL_TOP;
                state_next = S_Q_LIFT;
            end
            S_Q_LIFT:
            begin
                if ((diff_reg >> lvl_reg) != NODE_W'(0))
                begin
                    anc_rrow   = a_reg;
                    anc_rlvl   = lvl_reg;
                    state_next = S_Q_LFTW;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = S_Q_CMP;
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            S_Q_LFTW:
            begin
                a_next    = anc_val;
                diff_next = diff_reg - (NODE_W'(1) << lvl_reg);
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_CMP;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = S_Q_LIFT;
                end
            end
            S_Q_CMP:
            begin
                if (a_reg == b_reg)
                begin
                    fv_next    = a_reg;
                    lnk_raddr  = a_reg;
                    ret_next   = RET_Q;
                    state_next = S_FIND;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = S_Q_UPA;
                end
            end
            S_Q_UPA:
            begin
                anc_rrow   = a_reg;
                anc_rlvl   = lvl_reg;
                state_next = S_Q_UPB;
            end
            S_Q_UPB:
            begin
                pa_next    = anc_val;
                anc_rrow   = b_reg;
                anc_rlvl   = lvl_reg;
                state_next = S_Q_UPC;
            end
            S_Q_UPC:
            begin
                if (pa_reg != anc_val)
                begin
                    a_next = pa_reg;
                    b_next = anc_val;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_FIN;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = S_Q_UPA;
                end
            end
            S_Q_FIN:
            begin
                anc_rrow   = a_reg;
                anc_rlvl   = '0;
                state_next = S_Q_FINW;
            end
            S_Q_FINW:
            begin
                fv_next    = anc_val;
                lnk_raddr  = anc_val;
                ret_next   = RET_Q;
                state_next = S_FIND;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ret_reg         <= RET_X;
            next_node_reg   <= CNT_W'(1);
            root_erased_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            next_node_reg   <= next_node_next;
            root_erased_reg <= root_erased_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        n_reg        <= n_next;
        diff_reg     <= diff_next;
        da_reg       <= da_next;
        pa_reg       <= pa_next;
        fv_reg       <= fv_next;
        xv_reg       <= xv_next;
        yv_reg       <= yv_next;
        lvl_reg      <= lvl_next;
        res_reg      <= res_next;
        anc_zero_reg <= (anc_rrow < NODE_W'(2));
        dep_zero_reg <= (dep_raddr < NODE_W'(2));
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* design/gtlca_chk.sv */
// gtlca_chk: port-level checker for the growing tree lca core, with its bind
// depends on gtlca_pkg
`timescale 1ns / 1ps

module gtlca_chk
    import gtlca_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input cmd_t    cmd,
    input logic    done,
    input result_t result
);

    // an accepted beat either answers at once or starts the sequencer
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted beat neither answered nor started");

    // a failed command never carries an answer
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.answer == '0)
        else $error("error result with nonzero answer");

    // leaving the busy phase always delivers the result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy ended without a result");

    // no result appears while the sequencer is still working
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result while busy");

endmodule

bind growing_tree_lca_with_deletions_core gtlca_chk u_gtlca_chk (.*);

/* test/testbench.sv */
// testbench: random and directed checks of the growing tree lca core against
// an in-bench tree model with lifting tables and union-find links
// depends on gtlca_pkg and growing_tree_lca_with_deletions_core
`timescale 1ns / 1ps

module testbench;
    import gtlca_pkg::*;

    class lca_scoreboard;
        int unsigned lift [MAX_NODES][LOG_LEVELS];
        int unsigned depth_of [MAX_NODES];
        int unsigned link [MAX_NODES];
        int unsigned top_node;
        result_t pending [$];
        int errors;

        function new();
            link[0] = 0;
            link[1] = 1;
            top_node = 1;
            errors = 0;
        endfunction

        function bit allocated(int unsigned v);
            return v >= 1 && v <= top_node && v < MAX_NODES;
        endfunction

        function int unsigned find_alive(int unsigned v);
            int unsigned nxt;
            for (int s = 0; s < MAX_NODES; s++)
            begin
                if (v >= MAX_NODES)
                    return 0;
                nxt = link[v];
                if (nxt == v)
                    break;
                v = nxt;
            end
            return v;
        endfunction

        function int unsigned meet(int unsigned a, int unsigned b);
            int unsigned t, gap, pa, pb;
            if (depth_of[a] < depth_of[b])
            begin
                t = a;
                a = b;
                b = t;
            end
            for (int i = LOG_LEVELS - 1; i >= 0; i--)
            begin
                gap = (depth_of[a] >= depth_of[b]) ? depth_of[a] - depth_of[b] : 0;
                if ((1 << i) <= gap)
                    a = lift[a][i];
            end
            if (a == b)
                return a;
            for (int i = LOG_LEVELS - 1; i >= 0; i--)
            begin
                pa = lift[a][i];
                pb = lift[b][i];
                if (pa != pb)
                begin
                    a = pa;
                    b = pb;
                end
            end
            return lift[a][0];
        endfunction

        function void note(cmd_t c);
            result_t r;
            int unsigned a, b, n, x, y;
            a = c.node_a;
            b = c.node_b;
            r.answer = '0;
            r.status = ST_OK;
            case (c.op)
                OP_INSERT:
                    if (!allocated(a))
                        r.status = ST_NO_NODE;
                    else if (top_node + 1 >= MAX_NODES)
                        r.status = ST_FULL;
                    else
                    begin
                        n = top_node + 1;
                        top_node = n;
                        link[n] = n;
                        depth_of[n] = depth_of[a] + 1;
                        lift[n][0] = a;
                        for (int i = 1; i < LOG_LEVELS; i++)
                            lift[n][i] = lift[lift[n][i-1]][i-1];
                        r.answer = n;
                    end
                OP_ERASE:
                    if (!allocated(a))
                        r.status = ST_NO_NODE;
                    else
                    begin
                        x = find_alive(a);
                        y = find_alive(lift[a][0]);
                        if (x != y && x < MAX_NODES)
                            link[x] = y;
                    end
                OP_QUERY:
                    if (!allocated(a) || !allocated(b))
                        r.status = ST_NO_NODE;
                    else
                        r.answer = find_alive(meet(a, b));
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected beat answer %0d status %0d",
                                 got.answer, got.status));
                return;
            end
            want = pending.pop_front();
            if (got.answer !== want.answer)
                report($sformatf("answer %0d, want %0d", got.answer, want.answer));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 20000000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    lca_scoreboard sb;
    int cycles;
    int idle_pct;

    growing_tree_lca_with_deletions_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note(cmd);
        if (rst_n && done)
            sb.check(result);
    end

    task send(op_t op, int unsigned a, int unsigned b);
        start <= 1'b1;
        cmd.op <= op;
        cmd.node_a <= a[NODE_W-1:0];
        cmd.node_b <= b[NODE_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function int unsigned pick_node();
        if ($urandom_range(1))
            return sb.top_node - $urandom_range(0, (sb.top_node > 3) ? 3 : sb.top_node - 1);
        return $urandom_range(1, sb.top_node);
    endfunction

    task random_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            send(OP_INSERT, pick_node(), $urandom_range(1023));
        else if (r < 72)
            send(OP_ERASE, $urandom_range(2, sb.top_node > 2 ? sb.top_node : 2),
                 $urandom_range(1023));
        else if (r < 94)
            send(OP_QUERY, pick_node(), $urandom_range(1, sb.top_node));
        else if (r < 97)
            send(op_t'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023));
        else
            send(OP_NONE, $urandom_range(1023), $urandom_range(1023));
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        idle_pct = 29;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_QUERY, 1, 1);
        send(OP_INSERT, 1, 0);
        send(OP_INSERT, 2, 1023);
        send(OP_INSERT, 3, 0);
        send(OP_INSERT, 1, 0);
        send(OP_QUERY, 4, 5);
        send(OP_QUERY, 4, 3);
        send(OP_INSERT, 0, 0);
        send(OP_INSERT, 1023, 0);
        send(OP_ERASE, 0, 0);
        send(OP_ERASE, 6, 0);
        send(OP_QUERY, 0, 2);
        send(OP_QUERY, 2, 1023);
        send(OP_NONE, 1023, 1023);
        send(OP_NONE, 0, 0);
        send(OP_ERASE, 3, 0);
        send(OP_QUERY, 4, 4);
        send(OP_ERASE, 3, 0);
        send(OP_ERASE, 2, 0);
        send(OP_QUERY, 4, 5);

        for (int k = 0; k < 1800; k++)
        begin
            if (k == 600)
                idle_pct = 73;
            else if (k == 1200)
                idle_pct = 0;
            random_item();
        end
        while (sb.top_node + 1 < MAX_NODES)
            send(OP_INSERT, pick_node(), 0);
        send(OP_INSERT, 1, 0);
        send(OP_INSERT, sb.top_node, 0);
        send(OP_QUERY, sb.top_node, sb.top_node - 1);
        send(OP_ERASE, 1, 0);
        send(OP_QUERY, sb.top_node, 2);
        send(OP_ERASE, 1, 0);
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/gtlca_pkg.sv
design/gtlca_ram.sv
design/growing_tree_lca_with_deletions_core.sv
design/gtlca_chk.sv
test/testbench.sv
